// File: rtl/core/dh_pkg.sv
// ----------------------------------------------------------------------------
// dh_pkg
// shared widths, carry records and helper functions of the torsion core
// ----------------------------------------------------------------------------
package dh_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 15;
  localparam int ARC_STAGES_DEF      = 16;

  localparam int BOND_BITS   = 20;
  localparam int NORM_BITS   = 20;
  localparam int CORDIC_BITS = 30;
  localparam int Z_FRAC      = 30;

  localparam int BW       = BOND_BITS + 1;  // shifted bond / normal component
  localparam int PW       = 2 * BW;         // one product of two components
  localparam int NW       = PW + 1;         // cross product component
  localparam int DW       = PW + 2;         // three-term dot product
  localparam int SQ_W     = DW;             // root recurrence width
  localparam int SQ_STEPS = BW;             // root bits
  localparam int XY_W     = CORDIC_BITS + 4;
  localparam int Z_W      = 34;
  localparam int WIDE     = 64;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic [2:0][NW-1:0] m;
    logic [DW-1:0]      dn;
    logic [2:0][BW-1:0] n2;
    logic               deg;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    vec_t            vec;
  } sq_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
    logic            deg;
  } cor_t;

  function automatic logic [WIDE-1:0] mag64(input logic signed [WIDE-1:0] v);
    mag64 = v[WIDE-1] ? WIDE'(-v) : WIDE'(v);
  endfunction

  // right shift that brings every magnitude below 2^bits
  function automatic logic [6:0] blk_shamt(input logic [WIDE-1:0] m, input int bits);
    int bl;
    bl = 0;
    for (int i = 0; i < WIDE; i++) begin
      if (m[i]) bl = i + 1;
    end
    blk_shamt = (bl > bits) ? 7'(bl - bits) : 7'd0;
  endfunction

  function automatic logic [31:0] atan_q30(input int i);
    case (i)
      0:  atan_q30 = 32'd843314856;
      1:  atan_q30 = 32'd497837829;
      2:  atan_q30 = 32'd263043836;
      3:  atan_q30 = 32'd133525158;
      4:  atan_q30 = 32'd67021686;
      5:  atan_q30 = 32'd33543515;
      6:  atan_q30 = 32'd16775850;
      7:  atan_q30 = 32'd8388437;
      8:  atan_q30 = 32'd4194282;
      9:  atan_q30 = 32'd2097149;
      10: atan_q30 = 32'd1048575;
      11: atan_q30 = 32'd524287;
      12: atan_q30 = 32'd262143;
      13: atan_q30 = 32'd131071;
      14: atan_q30 = 32'd65535;
      15: atan_q30 = 32'd32767;
      16: atan_q30 = 32'd16383;
      17: atan_q30 = 32'd8191;
      18: atan_q30 = 32'd4095;
      19: atan_q30 = 32'd2047;
      20: atan_q30 = 32'd1023;
      21: atan_q30 = 32'd511;
      22: atan_q30 = 32'd255;
      23: atan_q30 = 32'd127;
      24: atan_q30 = 32'd63;
      25: atan_q30 = 32'd31;
      26: atan_q30 = 32'd15;
      27: atan_q30 = 32'd7;
      28: atan_q30 = 32'd3;
      29: atan_q30 = 32'd1;
      default: atan_q30 = 32'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/dh_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dh_sqrt_cell
// one digit step of the integer square root, vector data rides along
// ----------------------------------------------------------------------------
module dh_sqrt_cell
  import dh_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  input  sq_t  up_dat,
  output logic up_en,
  output logic dn_vld,
  output sq_t  dn_dat,
  input  logic dn_en
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * IDX);

  logic vld_r;
  sq_t  dat_r, dat_nxt;
  logic [SQ_W-1:0] trial;

  assign up_en = !vld_r || dn_en;

  always_comb begin
    dat_nxt = up_dat;
    trial   = up_dat.root + BIT;
    if (up_dat.rem >= trial) begin
      dat_nxt.rem  = up_dat.rem - trial;
      dat_nxt.root = (up_dat.root >> 1) + BIT;
    end else begin
      dat_nxt.root = up_dat.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_en) begin
      vld_r <= up_vld;
    end
    if (up_en) dat_r <= dat_nxt;
  end

  assign dn_vld = vld_r;
  assign dn_dat = dat_r;

endmodule

// File: rtl/core/dh_cordic_cell.sv
// ----------------------------------------------------------------------------
// dh_cordic_cell
// one vectoring rotation of the arc tangent chain
// ----------------------------------------------------------------------------
module dh_cordic_cell
  import dh_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  input  cor_t up_dat,
  output logic up_en,
  output logic dn_vld,
  output cor_t dn_dat,
  input  logic dn_en
);

  localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_q30(IDX));

  logic vld_r;
  cor_t dat_r, dat_nxt;
  logic signed [XY_W-1:0] x, y, dx, dy;
  logic signed [Z_W-1:0]  z;

  assign up_en = !vld_r || dn_en;

  always_comb begin
    x  = $signed(up_dat.x);
    y  = $signed(up_dat.y);
    z  = $signed(up_dat.z);
    dx = y >>> IDX;
    dy = x >>> IDX;
    dat_nxt = up_dat;
    if (!y[XY_W-1]) begin
      dat_nxt.x = x + dx;
      dat_nxt.y = y - dy;
      dat_nxt.z = z + ANG;
    end else begin
      dat_nxt.x = x - dx;
      dat_nxt.y = y + dy;
      dat_nxt.z = z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_en) begin
      vld_r <= up_vld;
    end
    if (up_en) dat_r <= dat_nxt;
  end

  assign dn_vld = vld_r;
  assign dn_dat = dat_r;

endmodule

// File: rtl/core/dh_front.sv
// ----------------------------------------------------------------------------
// dh_front
// bond vectors, plane normals and the dot products that feed the root chain
// ----------------------------------------------------------------------------
module dh_front
  import dh_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_vld,
  input  logic [COORD_WIDTH-1:0] up_pt [4][3],
  output logic                   up_en,
  output logic                   dn_vld,
  output sq_t                    dn_dat,
  input  logic                   dn_en
);

  localparam int DCW = COORD_WIDTH + 1;
  localparam int NST = 9;

  logic v_r [NST];
  logic en  [NST+1];

  always_comb begin
    en[NST] = dn_en;
    for (int s = NST - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  assign up_en  = en[0];
  assign dn_vld = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) v_r[s] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= up_vld;
      for (int s = 1; s < NST; s++) if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  // raw differences
  logic signed [DCW-1:0] d0_r [3][3];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          d0_r[i][k] <= $signed({up_pt[i+1][k][COORD_WIDTH-1], up_pt[i+1][k]})
                      - $signed({up_pt[i][k][COORD_WIDTH-1], up_pt[i][k]});
    end
  end

  // bond magnitudes
  logic signed [DCW-1:0] d1_r [3][3];
  logic [WIDE-1:0]       bo_r [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        bo_r[i] <= mag64(WIDE'(d0_r[i][0])) | mag64(WIDE'(d0_r[i][1]))
                 | mag64(WIDE'(d0_r[i][2]));
        for (int k = 0; k < 3; k++) d1_r[i][k] <= d0_r[i][k];
      end
    end
  end

  // shifted bonds
  logic signed [BW-1:0] b_r [3][3];
  logic [6:0]           bs  [3];
  logic signed [WIDE-1:0] bw [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bs[i] = blk_shamt(bo_r[i], BOND_BITS);
      for (int k = 0; k < 3; k++) bw[i][k] = WIDE'(d1_r[i][k]) >>> bs[i];
    end
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) b_r[i][k] <= bw[i][k][BW-1:0];
    end
  end

  // normal products, q = 0 gives b1 x b2, q = 1 gives b2 x b3
  logic signed [PW-1:0] pa_r [2][3];
  logic signed [PW-1:0] pb_r [2][3];
  logic signed [BW-1:0] b2_3_r [3];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int q = 0; q < 2; q++)
        for (int j = 0; j < 3; j++) begin
          pa_r[q][j] <= b_r[q][(j+1)%3] * b_r[q+1][(j+2)%3];
          pb_r[q][j] <= b_r[q][(j+2)%3] * b_r[q+1][(j+1)%3];
        end
      for (int k = 0; k < 3; k++) b2_3_r[k] <= b_r[1][k];
    end
  end

  // normals and zero check
  logic signed [NW-1:0] n_r [2][3];
  logic signed [BW-1:0] b2_4_r [3];
  logic                 deg4_r;
  logic signed [NW-1:0] nd [2][3];
  logic                 nz [2];
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      for (int j = 0; j < 3; j++) nd[q][j] = NW'(pa_r[q][j]) - NW'(pb_r[q][j]);
      nz[q] = (nd[q][0] == '0) && (nd[q][1] == '0) && (nd[q][2] == '0);
    end
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int q = 0; q < 2; q++)
        for (int j = 0; j < 3; j++) n_r[q][j] <= nd[q][j];
      for (int k = 0; k < 3; k++) b2_4_r[k] <= b2_3_r[k];
      deg4_r <= nz[0] || nz[1];
    end
  end

  // normal magnitudes
  logic signed [NW-1:0] n5_r [2][3];
  logic [WIDE-1:0]      no_r [2];
  logic signed [BW-1:0] b2_5_r [3];
  logic                 deg5_r;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int q = 0; q < 2; q++) begin
        no_r[q] <= mag64(WIDE'(n_r[q][0])) | mag64(WIDE'(n_r[q][1]))
                 | mag64(WIDE'(n_r[q][2]));
        for (int j = 0; j < 3; j++) n5_r[q][j] <= n_r[q][j];
      end
      for (int k = 0; k < 3; k++) b2_5_r[k] <= b2_4_r[k];
      deg5_r <= deg4_r;
    end
  end

  // shifted normals
  logic signed [BW-1:0]   ns_r [2][3];
  logic signed [BW-1:0]   b2_6_r [3];
  logic                   deg6_r;
  logic [6:0]             nsh [2];
  logic signed [WIDE-1:0] nw  [2][3];
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      nsh[q] = blk_shamt(no_r[q], NORM_BITS);
      for (int j = 0; j < 3; j++) nw[q][j] = WIDE'(n5_r[q][j]) >>> nsh[q];
    end
  end
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int q = 0; q < 2; q++)
        for (int j = 0; j < 3; j++) ns_r[q][j] <= nw[q][j][BW-1:0];
      for (int k = 0; k < 3; k++) b2_6_r[k] <= b2_5_r[k];
      deg6_r <= deg5_r;
    end
  end

  // products for b2 x n1, n1.n2 and b2.b2
  logic signed [PW-1:0] ma_r [3];
  logic signed [PW-1:0] mb_r [3];
  logic signed [PW-1:0] dp_r [3];
  logic signed [PW-1:0] sp_r [3];
  logic signed [BW-1:0] n2_7_r [3];
  logic                 deg7_r;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int j = 0; j < 3; j++) begin
        ma_r[j]   <= b2_6_r[(j+1)%3] * ns_r[0][(j+2)%3];
        mb_r[j]   <= b2_6_r[(j+2)%3] * ns_r[0][(j+1)%3];
        dp_r[j]   <= ns_r[0][j] * ns_r[1][j];
        sp_r[j]   <= b2_6_r[j] * b2_6_r[j];
        n2_7_r[j] <= ns_r[1][j];
      end
      deg7_r <= deg6_r;
    end
  end

  // sums, seed of the root chain
  sq_t out_r, out_nxt;
  always_comb begin
    out_nxt.root    = '0;
    out_nxt.rem     = SQ_W'(sp_r[0]) + SQ_W'(sp_r[1]) + SQ_W'(sp_r[2]);
    out_nxt.vec.dn  = DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
    for (int j = 0; j < 3; j++) begin
      out_nxt.vec.m[j]  = NW'(ma_r[j]) - NW'(mb_r[j]);
      out_nxt.vec.n2[j] = n2_7_r[j];
    end
    out_nxt.vec.deg = deg7_r;
  end
  always_ff @(posedge clk) begin
    if (en[8]) out_r <= out_nxt;
  end

  assign dn_dat = out_r;

endmodule

// File: rtl/core/dihedral_angle_four_points_core.sv
// ----------------------------------------------------------------------------
// dihedral_angle_four_points_core
// signed torsion angle of four points about the middle bond
// ----------------------------------------------------------------------------
// a result passes the front end, the root cells, the middle stages, the cordic cells and the output register
// throughput: one beat per cycle when no stall holds the chain, every stage is a register in a single chain
// stalls collapse bubbles stage by stage, so input keeps flowing while a result waits
// reset: synchronous active-low rst_n clears all valid flags, payload is not reset
// ----------------------------------------------------------------------------
module dihedral_angle_four_points_core
  import dh_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int ARC_STAGES      = ARC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_a_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_y,
  input  logic signed [COORD_WIDTH-1:0]     in_a_z,
  input  logic signed [COORD_WIDTH-1:0]     in_b_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_y,
  input  logic signed [COORD_WIDTH-1:0]     in_b_z,
  input  logic signed [COORD_WIDTH-1:0]     in_c_x,
  input  logic signed [COORD_WIDTH-1:0]     in_c_y,
  input  logic signed [COORD_WIDTH-1:0]     in_c_z,
  input  logic signed [COORD_WIDTH-1:0]     in_d_x,
  input  logic signed [COORD_WIDTH-1:0]     in_d_y,
  input  logic signed [COORD_WIDTH-1:0]     in_d_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_torsion,
  output logic                              out_degenerate
);

  localparam int TW  = ANGLE_FRAC_BITS + 3;
  localparam int ZSH = Z_FRAC - ANGLE_FRAC_BITS;
  localparam longint LIM = (PI_Q30 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
  localparam int NT  = 5;

  // ---------------------------------------------------------------- front end
  logic [COORD_WIDTH-1:0] pts [4][3];
  assign pts[0][0] = in_a_x;  assign pts[0][1] = in_a_y;  assign pts[0][2] = in_a_z;
  assign pts[1][0] = in_b_x;  assign pts[1][1] = in_b_y;  assign pts[1][2] = in_b_z;
  assign pts[2][0] = in_c_x;  assign pts[2][1] = in_c_y;  assign pts[2][2] = in_c_z;
  assign pts[3][0] = in_d_x;  assign pts[3][1] = in_d_y;  assign pts[3][2] = in_d_z;

  logic front_en;
  logic sq_vld [SQ_STEPS+1];
  sq_t  sq_dat [SQ_STEPS+1];
  logic sq_en  [SQ_STEPS+1];

  dh_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_vld (in_valid),
    .up_pt  (pts),
    .up_en  (front_en),
    .dn_vld (sq_vld[0]),
    .dn_dat (sq_dat[0]),
    .dn_en  (sq_en[0])
  );

  assign in_stall = !front_en;

  // --------------------------------------------------- square root of b2.b2
  // one cell per root bit, highest bit first
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    dh_sqrt_cell #(.IDX(SQ_STEPS - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (sq_vld[j]),
      .up_dat (sq_dat[j]),
      .up_en  (sq_en[j]),
      .dn_vld (sq_vld[j+1]),
      .dn_dat (sq_dat[j+1]),
      .dn_en  (sq_en[j+1])
    );
  end

  // ---------------------------------------------------- middle stage control
  logic v_r [NT];
  logic en  [NT+1];
  logic cr_vld [ARC_STAGES+1];
  cor_t cr_dat [ARC_STAGES+1];
  logic cr_en  [ARC_STAGES+1];

  always_comb begin
    en[NT] = cr_en[0];
    for (int s = NT - 1; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end
  assign sq_en[SQ_STEPS] = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NT; s++) v_r[s] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= sq_vld[SQ_STEPS];
      for (int s = 1; s < NT; s++) if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  // partial products, wide operands split at bit 22 to keep multipliers small
  localparam int SPL = 22;
  vec_t sv;
  logic [BW-1:0] root;
  assign sv   = sq_dat[SQ_STEPS].vec;
  assign root = sq_dat[SQ_STEPS].root[BW-1:0];

  logic [SPL+BW-1:0]            xl_r;
  logic signed [DW-SPL+BW:0]    xh_r;
  logic signed [SPL+BW:0]       yl_r [3];
  logic signed [NW-SPL+BW-1:0]  yh_r [3];
  logic                         deg0_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xl_r <= sv.dn[SPL-1:0] * root;
      xh_r <= $signed(sv.dn[DW-1:SPL]) * $signed({1'b0, root});
      for (int j = 0; j < 3; j++) begin
        yl_r[j] <= $signed({1'b0, sv.m[j][SPL-1:0]}) * $signed(sv.n2[j]);
        yh_r[j] <= $signed(sv.m[j][NW-1:SPL]) * $signed(sv.n2[j]);
      end
      deg0_r <= sv.deg;
    end
  end

  // x = (n1.n2) * |b2|, y = (b2 x n1).n2
  logic signed [WIDE-1:0] x1_r, y1_r, ysum;
  logic                   deg1_r;
  always_comb begin
    ysum = '0;
    for (int j = 0; j < 3; j++)
      ysum = ysum + (WIDE'(yh_r[j]) <<< SPL) + WIDE'(yl_r[j]);
  end
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1_r   <= (WIDE'(xh_r) <<< SPL) + WIDE'(xl_r);
      y1_r   <= ysum;
      deg1_r <= deg0_r;
    end
  end

  // vanishing operands and joint magnitude
  logic signed [WIDE-1:0] x2_r, y2_r;
  logic [WIDE-1:0]        mo_r;
  logic                   deg2_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      mo_r   <= mag64(x1_r) | mag64(y1_r);
      deg2_r <= deg1_r || ((x1_r == '0) && (y1_r == '0));
    end
  end

  // joint block shift into cordic range
  logic signed [XY_W-1:0] x3_r, y3_r;
  logic                   deg3_r;
  logic [6:0]             xsh;
  logic signed [WIDE-1:0] xw, yw;
  always_comb begin
    xsh = blk_shamt(mo_r, CORDIC_BITS);
    xw  = x2_r >>> xsh;
    yw  = y2_r >>> xsh;
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      x3_r   <= xw[XY_W-1:0];
      y3_r   <= yw[XY_W-1:0];
      deg3_r <= deg2_r;
    end
  end

  // quarter turn when x is negative, toward the sign of y
  cor_t pre_r, pre_nxt;
  always_comb begin
    pre_nxt.deg = deg3_r;
    pre_nxt.x   = x3_r;
    pre_nxt.y   = y3_r;
    pre_nxt.z   = '0;
    if (x3_r[XY_W-1]) begin
      if (!y3_r[XY_W-1]) begin
        pre_nxt.x = y3_r;
        pre_nxt.y = -x3_r;
        pre_nxt.z = Z_W'(HALF_PI_Q30);
      end else begin
        pre_nxt.x = -y3_r;
        pre_nxt.y = x3_r;
        pre_nxt.z = Z_W'(-HALF_PI_Q30);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en[4]) pre_r <= pre_nxt;
  end

  assign cr_vld[0] = v_r[NT-1];
  assign cr_dat[0] = pre_r;

  // ------------------------------------------------------- cordic rotations
  for (genvar i = 0; i < ARC_STAGES; i++) begin : g_cordic
    dh_cordic_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (cr_vld[i]),
      .up_dat (cr_dat[i]),
      .up_en  (cr_en[i]),
      .dn_vld (cr_vld[i+1]),
      .dn_dat (cr_dat[i+1]),
      .dn_en  (cr_en[i+1])
    );
  end

  // ---------------------------------------------------------- output beat
  // round half up, clamp to +-pi, force zero for degenerate geometry
  logic                 out_valid_r;
  logic signed [TW-1:0] torsion_r, torsion_nxt;
  logic                 degen_r;
  logic                 out_en;
  logic signed [WIDE-1:0] zr, ang;
  cor_t                 fin;

  assign fin    = cr_dat[ARC_STAGES];
  assign out_en = !out_valid_r || !out_stall;
  assign cr_en[ARC_STAGES] = out_en;

  always_comb begin
    zr  = WIDE'($signed(fin.z));
    ang = (zr + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
    if (ang > LIM)  ang = LIM;
    if (ang < -LIM) ang = -LIM;
    torsion_nxt = fin.deg ? '0 : ang[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= cr_vld[ARC_STAGES];
    end
    if (out_en) begin
      torsion_r <= torsion_nxt;
      degen_r   <= fin.deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_torsion    = torsion_r;
  assign out_degenerate = degen_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams random and directed point quadruples through the torsion core and
// checks every angle and degenerate flag against an integer predictor
// ----------------------------------------------------------------------------

// expected angles in arrival order, compared as results come out
class torsion_scoreboard;
  logic [17:0] exp_angle[$];
  logic        exp_deg[$];
  int          n_fail;
  int          n_checked;
  int          n_deg;

  function void note_quad(logic [17:0] ang, logic dg);
    exp_angle.push_back(ang);
    exp_deg.push_back(dg);
  endfunction

  function void check_result(logic [17:0] ang, logic dg);
    logic [17:0] ea;
    logic        ed;
    if (exp_angle.size() == 0) begin
      $error("result beat with nothing expected: torsion %0d", $signed(ang));
      n_fail++;
      return;
    end
    ea = exp_angle.pop_front();
    ed = exp_deg.pop_front();
    n_checked++;
    if (ed) n_deg++;
    if (ea !== ang) begin
      $error("torsion mismatch: expected %0d actual %0d", $signed(ea), $signed(ang));
      n_fail++;
    end
    if (ed !== dg) begin
      $error("degenerate mismatch: expected %0b actual %0b", ed, dg);
      n_fail++;
    end
  endfunction
endclass

module tb;
  import dh_pkg::*;

  localparam int ARC_N   = 16;
  localparam int LATENCY = 36 + ARC_N;
  localparam int N_RAND  = 1100;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic signed [31:0] in_c_x, in_c_y, in_c_z, in_d_x, in_d_y, in_d_z;
  logic out_valid;
  logic out_stall;
  logic signed [17:0] out_torsion;
  logic out_degenerate;

  torsion_scoreboard sb;
  bit quiet_phase;   // no idling on either side near the end
  bit hold_out;      // long receiver hold-off
  int n_sent;

  dihedral_angle_four_points_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .in_d_x(in_d_x), .in_d_y(in_d_y), .in_d_z(in_d_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_torsion(out_torsion), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  // arithmetic shift right, flooring
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // shift a group right until each magnitude fits under 2^bits
  function automatic void fit_group(ref longint v[3], input int n, input int bits);
    longint unsigned m, a;
    int s;
    m = 0;
    s = 0;
    for (int i = 0; i < n; i++) begin
      a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (a > m) m = a;
    end
    while ((m >> s) >= (64'd1 << bits)) s++;
    for (int i = 0; i < n; i++) v[i] = floor_shr(v[i], s);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot3(input longint a[3], input longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_atan(longint x, longint y);
    longint z, t, dx, dy;
    longint atab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                         524287, 262143, 131071, 65535, 32767};
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < ARC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atab[i];
      end else begin
        x -= dx; y += dy; z -= atab[i];
      end
    end
    return z;
  endfunction

  // points packed as a.x a.y a.z b.x ... d.z
  function automatic void predict_torsion(input logic signed [31:0] c[12],
                                          output logic [17:0] ang_o, output logic dg);
    longint b0[3], b1[3], b2[3], n1[3], n2[3], m[3], xy[3];
    longint z, ang, lim;
    dg = 1'b0;
    ang = 0;
    for (int k = 0; k < 3; k++) begin
      b0[k] = longint'(c[3 + k]) - longint'(c[k]);
      b1[k] = longint'(c[6 + k]) - longint'(c[3 + k]);
      b2[k] = longint'(c[9 + k]) - longint'(c[6 + k]);
    end
    fit_group(b0, 3, BOND_BITS);
    fit_group(b1, 3, BOND_BITS);
    fit_group(b2, 3, BOND_BITS);
    cross3(b0, b1, n1);
    cross3(b1, b2, n2);
    if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
        (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
      dg = 1'b1;
    end else begin
      fit_group(n1, 3, NORM_BITS);
      fit_group(n2, 3, NORM_BITS);
      cross3(b1, n1, m);
      xy[0] = dot3(n1, n2) * longint'(root_floor(dot3(b1, b1)));
      xy[1] = dot3(m, n2);
      xy[2] = 0;
      if (xy[0] == 0 && xy[1] == 0) begin
        dg = 1'b1;
      end else begin
        fit_group(xy, 2, CORDIC_BITS);
        z = vector_atan(xy[0], xy[1]);
        ang = (z + (64'sd1 << (Z_FRAC - 15 - 1))) >>> (Z_FRAC - 15);
        lim = (PI_Q30 + (64'sd1 << (Z_FRAC - 15 - 1))) >>> (Z_FRAC - 15);
        if (ang > lim) ang = lim;
        if (ang < -lim) ang = -lim;
      end
    end
    ang_o = ang[17:0];
  endfunction

  // ---------------- drivers ----------------

  // offer one quadruple and hold it until accepted
  task automatic send_quad(input logic signed [31:0] c[12]);
    logic [17:0] ea;
    logic        ed;
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_a_x, in_a_y, in_a_z} <= {c[0], c[1], c[2]};
    {in_b_x, in_b_y, in_b_z} <= {c[3], c[4], c[5]};
    {in_c_x, in_c_y, in_c_z} <= {c[6], c[7], c[8]};
    {in_d_x, in_d_y, in_d_z} <= {c[9], c[10], c[11]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_torsion(c, ea, ed);
    sb.note_quad(ea, ed);
    n_sent++;
  endtask

  // one coordinate: a scale picked at random so every bit gets exercised
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      2: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
      default: return $signed($urandom_range(0, 32'h3FF)) - 32'sh200;
    endcase
  endfunction

  // a quadruple; sometimes degenerate by construction
  task automatic random_quad();
    logic signed [31:0] c[12];
    int mode;
    mode = $urandom_range(0, 19);
    for (int i = 0; i < 12; i++) c[i] = rand_coord();
    if (mode == 0) begin
      // repeated point, zero-length bond
      for (int k = 0; k < 3; k++) c[6 + k] = c[3 + k];
    end else if (mode == 1) begin
      // a on the line through b and c
      for (int k = 0; k < 3; k++) c[k] = c[3 + k] - (c[6 + k] - c[3 + k]);
    end else if (mode == 2) begin
      // planar molecule, angle near 0 or pi
      c[2] = 0; c[5] = 0; c[8] = 0; c[11] = 0;
    end
    send_quad(c);
  endtask

  task automatic directed_quads();
    logic signed [31:0] c[12];
    logic signed [31:0] one;
    one = 32'sh10000;
    // cis: angle 0
    c = '{0, one, 0,  0, 0, 0,  one, 0, 0,  one, one, 0};
    send_quad(c);
    // trans: anti-periplanar, pi
    c = '{0, one, 0,  0, 0, 0,  one, 0, 0,  one, -one, 0};
    send_quad(c);
    // plus and minus a quarter turn
    c = '{0, one, 0,  0, 0, 0,  one, 0, 0,  one, 0, one};
    send_quad(c);
    c = '{0, one, 0,  0, 0, 0,  one, 0, 0,  one, 0, -one};
    send_quad(c);
    // all points equal
    c = '{default: 32'sh1234};
    send_quad(c);
    // zero-length first and last bonds
    c = '{5, 6, 7,  5, 6, 7,  one, 0, 0,  one, one, 0};
    send_quad(c);
    c = '{0, one, 0,  0, 0, 0,  one, 0, 0,  one, 0, 0};
    send_quad(c);
    // collinear a, b, c
    c = '{-one, 0, 0,  0, 0, 0,  one, 0, 0,  one, one, one};
    send_quad(c);
    // extremes of the coordinate range
    c = '{32'sh80000000, 32'sh7FFFFFFF, 0,  32'sh7FFFFFFF, 32'sh80000000, 0,
          32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
          32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
    send_quad(c);
    c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
          0, 32'sh80000000, 0,  -1, -1, -1};
    send_quad(c);
    // tiny offsets, single lsb bonds
    c = '{0, 1, 0,  0, 0, 0,  1, 0, 0,  1, -1, 1};
    send_quad(c);
    c = '{-1, -1, -1,  0, 0, 0,  -1, 0, -1,  32'sh7FFFFFFF, -1, 32'sh80000000};
    send_quad(c);
  endtask

  // ---------------- receiver ----------------

  // random stall bursts, plus one long hold-off
  initial begin
    int gap;
    out_stall <= 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // sample result beats at the edge they are accepted
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_torsion, out_degenerate);
  end

  // ---------------- main sequence ----------------

  initial begin
    int wait_cyc;
    sb = new();
    quiet_phase = 1'b0;
    hold_out = 1'b0;
    n_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} <= '0;
    {in_c_x, in_c_y, in_c_z, in_d_x, in_d_y, in_d_z} <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_quads();
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 200) hold_out = 1'b1;   // fill the pipe while the sender keeps going
      if (i == N_RAND - 150) quiet_phase = 1'b1;
      random_quad();
    end
    in_valid <= 1'b0;

    wait_cyc = 0;
    while (sb.exp_angle.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d quadruples, %0d results checked, %0d degenerate",
             n_sent, sb.n_checked, sb.n_deg);
    if (sb.n_fail == 0 && sb.exp_angle.size() == 0) begin
      $display("tb passed");
    end else begin
      if (sb.exp_angle.size() != 0)
        $error("%0d results never arrived", sb.exp_angle.size());
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting on the core");
    $display("tb failed");
    $finish;
  end

endmodule
